[rtl/core/assert_macros.svh]
// Assertion helpers used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cell allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cell allocator assertion failed");

`endif

[rtl/core/cafs_pkg.sv]
`timescale 1ns / 1ps

package cafs_pkg;

   // Payload field widths
   localparam int OP_W     = 1;
   localparam int COUNT_W  = 11;
   localparam int ADDR_W   = 11;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 11;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // latch request, launch memory reads
      logic exec;        // commit a single-step request and load the result
      logic mark_start;  // set up a block run
      logic mark_step;   // claim one cell of a block run
      logic report;      // load the result of a finished block run
   } cafs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_multi;    // request is a block allocation that fits
      logic mark_last;   // current run step claims the last cell
      logic slot_free;   // result register can take a new transfer
   } cafs_sts_type;

endpackage

[rtl/core/cafs_if.sv]
`timescale 1ns / 1ps

// Request channel
interface cafs_req_if;
   logic                          valid;
   logic                          ready;
   logic [cafs_pkg::OP_W-1:0]     opcode;
   logic [cafs_pkg::COUNT_W-1:0]  cell_count;
   logic [cafs_pkg::ADDR_W-1:0]   cell_address;

   modport source (output valid, output opcode, output cell_count, output cell_address,
                   input ready);
   modport sink   (input valid, input opcode, input cell_count, input cell_address,
                   output ready);
endinterface

// Result channel
interface cafs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cafs_pkg::ADDR_W-1:0]   base_address;
   logic [cafs_pkg::STATUS_W-1:0] status;
   logic                          full_res;
   logic [cafs_pkg::LIVE_W-1:0]   live_count;

   modport source (output valid, output base_address, output status, output full_res,
                   output live_count, input ready);
   modport sink   (input valid, input base_address, input status, input full_res,
                   input live_count, output ready);
endinterface

[rtl/core/cell_allocator_free_stack.sv]
`timescale 1ns / 1ps
// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------
// req_chan  | in        | opcode, cell_count, cell_address
// rsp_chan  | out       | base_address, status, full_res, live_count
//
// Single-cell allocate, free and rejected requests are accepted first, which
// launches the free-stack and live-mark reads, and then committed.
// A block allocate of N cells makes one live-mark write per cell, then reports.
// Reset clears the pointers and counters at once; no clearing pass is needed.
// A result waiting in the output register stalls only the commit or report
// step; no new request is accepted until that step is done.
module cell_allocator_free_stack #(
   parameter int CELLS = 2048
) (
   input  logic         clock,
   input  logic         reset,
   cafs_req_if.sink     req_chan,
   cafs_rsp_if.source   rsp_chan
);

   cafs_pkg::cafs_cmd_type cmd;
   cafs_pkg::cafs_sts_type sts;

   // Sequencer
   cafs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Stack, marks, pointers and result register
   cafs_dp #(
      .CELLS (CELLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_chan.opcode),
      .req_cell_count   (req_chan.cell_count),
      .req_cell_address (req_chan.cell_address),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_base_address (rsp_chan.base_address),
      .rsp_status       (rsp_chan.status),
      .rsp_full_res     (rsp_chan.full_res),
      .rsp_live_count   (rsp_chan.live_count)
   );

endmodule

[rtl/core/cafs_ram.sv]
`timescale 1ns / 1ps

// Single write port, single registered read port.
module cafs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/cafs_ctrl.sv]
`timescale 1ns / 1ps

module cafs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output cafs_pkg::cafs_cmd_type cmd,
   input  cafs_pkg::cafs_sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_MARK   = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequencing: take request, resolve it, run block claims, report
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.is_multi) begin
               cmd.mark_start = 1'b1;
               state_in       = ST_MARK;
            end else if (sts.slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.mark_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (sts.slot_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/cafs_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cafs_dp #(
   parameter int CELLS = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cafs_pkg::cafs_cmd_type           cmd,
   output cafs_pkg::cafs_sts_type           sts,
   input  logic [cafs_pkg::OP_W-1:0]        req_opcode,
   input  logic [cafs_pkg::COUNT_W-1:0]     req_cell_count,
   input  logic [cafs_pkg::ADDR_W-1:0]      req_cell_address,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [cafs_pkg::ADDR_W-1:0]      rsp_base_address,
   output logic [cafs_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_full_res,
   output logic [cafs_pkg::LIVE_W-1:0]      rsp_live_count
);

   localparam int AW = $clog2(CELLS);      // cell index
   localparam int NW = AW + 1;             // bump pointer, holds CELLS
   localparam int DW = $clog2(CELLS + 1);  // stack depth 0..CELLS

   // Latched request
   logic [cafs_pkg::OP_W-1:0]    op_ff;
   logic [cafs_pkg::COUNT_W-1:0] count_ff;
   logic [cafs_pkg::ADDR_W-1:0]  addr_ff;

   // Allocator state
   logic [DW-1:0]                depth_ff, depth_in;
   logic [NW-1:0]                next_free_ff, next_free_in;
   logic [cafs_pkg::LIVE_W-1:0]  live_ff, live_in;
   logic [cafs_pkg::COUNT_W-1:0] remain_ff, remain_in;
   logic [cafs_pkg::ADDR_W-1:0]  base_ff, base_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cafs_pkg::ADDR_W-1:0]    rsp_base_ff, rsp_base_in;
   logic [cafs_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                           rsp_full_ff, rsp_full_in;
   logic [cafs_pkg::LIVE_W-1:0]    rsp_live_ff;

   // Memory ports
   logic                         stk_we;
   logic [AW-1:0]                stk_wa;
   logic [cafs_pkg::ADDR_W-1:0]  stk_rd;
   logic [AW-1:0]                stk_ra;
   logic                         mark_we;
   logic [AW-1:0]                mark_wa;
   logic                         mark_wd;
   logic                         mark_rd;

   // Decode helpers
   logic [NW-1:0]                 bump_next;
   logic                          exhausted;
   logic                          fits;
   logic                          addr_ok;
   logic                          addr_live;
   logic                          stack_full;
   logic                          multi_ok;
   logic [cafs_pkg::STATUS_W-1:0] exec_status;
   logic [cafs_pkg::ADDR_W-1:0]   exec_base;
   logic                          load;

   // Free stack of released cells
   cafs_ram #(
      .WIDTH (cafs_pkg::ADDR_W),
      .DEPTH (CELLS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (addr_ff),
      .rd_en   (cmd.accept),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // Live marks; cells above the bump pointer were never written and count as clear
   cafs_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_en   (cmd.accept),
      .rd_addr (AW'(req_cell_address)),
      .rd_data (mark_rd)
   );

   assign stk_ra     = AW'(depth_ff - DW'(1));
   assign bump_next  = next_free_ff + NW'(1);
   assign exhausted  = (32'(next_free_ff) + 32'd1) >= 32'(CELLS);
   assign fits       = (32'(next_free_ff) + 32'(count_ff)) < 32'(CELLS);
   assign addr_ok    = (addr_ff != '0) && (32'(addr_ff) < 32'(CELLS));
   assign addr_live  = mark_rd && (32'(addr_ff) <= 32'(next_free_ff));
   assign stack_full = 32'(depth_ff) >= 32'(CELLS);

   // Request resolution and state updates
   always_comb begin
      exec_status  = cafs_pkg::STATUS_OK;
      exec_base    = '0;
      multi_ok     = 1'b0;
      depth_in     = depth_ff;
      next_free_in = next_free_ff;
      live_in      = live_ff;
      remain_in    = remain_ff;
      base_in      = base_ff;
      stk_we       = 1'b0;
      stk_wa       = AW'(depth_ff);
      mark_we      = 1'b0;
      mark_wa      = AW'(bump_next);
      mark_wd      = 1'b1;

      unique case (op_ff)
         cafs_pkg::OP_ALLOC: begin
            if (count_ff == '0) begin
               exec_status = cafs_pkg::STATUS_BAD;
            end else if (count_ff == cafs_pkg::COUNT_W'(1)) begin
               if (depth_ff != '0) begin
                  // pop a released cell
                  exec_base = stk_rd;
                  if (cmd.exec) begin
                     depth_in = depth_ff - DW'(1);
                     mark_we  = 1'b1;
                     mark_wa  = AW'(stk_rd);
                     live_in  = live_ff + cafs_pkg::LIVE_W'(1);
                  end
               end else if (exhausted) begin
                  exec_status = cafs_pkg::STATUS_OOM;
               end else begin
                  // bump one cell
                  exec_base = cafs_pkg::ADDR_W'(bump_next);
                  if (cmd.exec) begin
                     next_free_in = bump_next;
                     mark_we      = 1'b1;
                     live_in      = live_ff + cafs_pkg::LIVE_W'(1);
                  end
               end
            end else if (!fits) begin
               exec_status = cafs_pkg::STATUS_OOM;
            end else begin
               multi_ok = 1'b1;
            end
         end
         cafs_pkg::OP_FREE: begin
            if (!addr_ok || !addr_live || stack_full) begin
               exec_status = cafs_pkg::STATUS_BAD;
            end else if (cmd.exec) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + DW'(1);
               mark_we  = 1'b1;
               mark_wa  = AW'(addr_ff);
               mark_wd  = 1'b0;
               live_in  = live_ff - cafs_pkg::LIVE_W'(1);
            end
         end
      endcase

      // block run: one cell per cycle right above the bump pointer
      if (cmd.mark_start) begin
         base_in   = cafs_pkg::ADDR_W'(bump_next);
         remain_in = count_ff;
      end
      if (cmd.mark_step) begin
         mark_we      = 1'b1;
         next_free_in = bump_next;
         live_in      = live_ff + cafs_pkg::LIVE_W'(1);
         remain_in    = remain_ff - cafs_pkg::COUNT_W'(1);
      end
   end

   // Result register: loads on exec or report, drains on transfer
   assign load          = cmd.exec || cmd.report;
   assign rsp_valid_in  = load || (rsp_valid_ff && !rsp_ready);
   assign rsp_base_in   = cmd.report ? base_ff : exec_base;
   assign rsp_status_in = cmd.report ? cafs_pkg::STATUS_OK : exec_status;
   assign rsp_full_in   = ((32'(next_free_in) + 32'd1) >= 32'(CELLS)) && (depth_in == '0);

   assign sts.is_multi  = multi_ok;
   assign sts.mark_last = remain_ff == cafs_pkg::COUNT_W'(1);
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         next_free_ff <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         next_free_ff <= next_free_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         count_ff <= req_cell_count;
         addr_ff  <= req_cell_address;
      end
      remain_ff <= remain_in;
      base_ff   <= base_in;
      if (load) begin
         rsp_base_ff   <= rsp_base_in;
         rsp_status_ff <= rsp_status_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_live_ff   <= live_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_base_address = rsp_base_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_full_res     = rsp_full_ff;
   assign rsp_live_count   = rsp_live_ff;

   `ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, 32'(depth_ff) <= 32'(CELLS))
   `ASSERT_NOW(a_run_in_range, clock, reset, cmd.mark_step, 32'(bump_next) < 32'(CELLS))
   `ASSERT_NEXT(a_bump_monotonic, clock, reset, !reset, next_free_ff >= $past(next_free_ff))
   `ASSERT_NOW(a_load_when_free, clock, reset, load, !rsp_valid_ff || rsp_ready)

endmodule
